FILE: src/perspective_point_projection_core_macros.svh
// assertion macros for the projection core
`ifndef PERSPECTIVE_POINT_PROJECTION_CORE_MACROS_SVH
`define PERSPECTIVE_POINT_PROJECTION_CORE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define PPP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ppp check failed: same-cycle implication");

// next-cycle implication
`define PPP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ppp check failed: next-cycle implication");

`else

`define PPP_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define PPP_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: src/ppp_pkg.sv
`timescale 1ns / 1ps

package ppp_pkg;

    // fraction bits of a world position
    localparam int COORD_FRAC_BITS_DEF = 12;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_FOV_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FOV_Y      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_W   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_H   = 3'd5;

    // commands
    localparam int CMD_W = 3;
    localparam logic [CMD_W-1:0] CMD_PROJECT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_CAMERA  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_RIGHT   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_UP      = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FORWARD = 3'd4;

    // field and datapath widths
    localparam int COORD_W = 32;
    localparam int FOV_W   = 16;
    localparam int SIZE_W  = 13;
    localparam int LOC_W   = COORD_W + 1;
    localparam int AXIS_W  = 16;
    localparam int PROD_W  = LOC_W + AXIS_W;
    localparam int T_W     = PROD_W + 2;
    localparam int MAG_W   = T_W - 1;
    localparam int NUM_SHIFT = 16;
    localparam int DEN_W   = FOV_W + MAG_W;
    localparam int QBITS   = 23;
    localparam int Q_W     = QBITS + 1;
    localparam int REM_W   = DEN_W + QBITS + 1;
    localparam int SCR_W   = 20;
    localparam int SCR_MAX = 2 ** (SCR_W - 1) - 1;
    localparam int SCR_MIN = -(2 ** (SCR_W - 1));

    // reset values of the registers
    localparam logic [FOV_W-1:0]  FOV_RESET      = 16'd4096;
    localparam logic [SIZE_W-1:0] SCREEN_W_RESET = 13'd1920;
    localparam logic [SIZE_W-1:0] SCREEN_H_RESET = 13'd1080;

    typedef struct packed {
        logic [CMD_W-1:0]          cmd;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_z;
    } in_item_t;

    typedef struct packed {
        logic signed [SCR_W-1:0] screen_x;
        logic signed [SCR_W-1:0] screen_y;
        logic                    point_valid;
        logic                    was_projection;
    } out_item_t;

    // live configuration seen by the pipeline
    typedef struct packed {
        logic [FOV_W-1:0]  fov_x;
        logic [FOV_W-1:0]  fov_y;
        logic [SIZE_W-1:0] screen_w;
        logic [SIZE_W-1:0] screen_h;
        logic              bad;
    } cfg_t;

    // camera-space point
    typedef struct packed {
        logic                  proj;
        logic signed [T_W-1:0] tx;
        logic signed [T_W-1:0] ty;
        logic signed [T_W-1:0] tz;
    } xf_item_t;

    // one divider lane
    typedef struct packed {
        logic             neg;
        logic             sat;
        logic [REM_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [Q_W-1:0]   q;
    } lane_t;

    typedef struct packed {
        logic  proj;
        logic  ok;
        lane_t x;
        lane_t y;
    } div_item_t;

endpackage

FILE: src/ppp_xform.sv
`timescale 1ns / 1ps

module ppp_xform
    import ppp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output xf_item_t  out_item
);

    logic signed [COORD_W-1:0] cam_reg [3];
    logic signed [AXIS_W-1:0]  axis_reg [9];

    logic                     s1_valid_reg;
    logic                     s1_proj_reg;
    logic signed [LOC_W-1:0]  s1_loc_reg [3];
    logic signed [AXIS_W-1:0] s1_axis_reg [9];

    logic                     s2_valid_reg;
    logic                     s2_proj_reg;
    logic signed [PROD_W-1:0] s2_prod_reg [9];

    logic                     s3_valid_reg;
    xf_item_t                 s3_item_reg;

    logic                      en1, en2, en3, take;
    logic signed [COORD_W-1:0] coord [3];
    logic signed [LOC_W-1:0]   loc_next [3];
    logic signed [PROD_W-1:0]  prod_next [9];
    xf_item_t                  s3_item_next;

    // stall chain
    assign en3      = !s3_valid_reg || out_ready;
    assign en2      = !s2_valid_reg || en3;
    assign en1      = !s1_valid_reg || en2;
    assign in_ready = en1;
    assign take     = in_valid && en1;

    assign out_valid = s3_valid_reg;
    assign out_item  = s3_item_reg;

    // offset from the camera
    always_comb
    begin
        coord[0] = in_item.coord_x;
        coord[1] = in_item.coord_y;
        coord[2] = in_item.coord_z;
        for (int i = 0; i < 3; i++)
        begin
            loc_next[i] = LOC_W'(coord[i]) - LOC_W'(cam_reg[i]);
        end
    end

    // camera state, written by load items
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                cam_reg[i] <= '0;
            end
            for (int k = 0; k < 9; k++)
            begin
                axis_reg[k] <= '0;
            end
        end
        else if (take)
        begin
            unique case (in_item.cmd)
                CMD_CAMERA:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        cam_reg[i] <= coord[i];
                    end
                end
                CMD_RIGHT:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        axis_reg[i] <= coord[i][AXIS_W-1:0];
                    end
                end
                CMD_UP:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        axis_reg[3 + i] <= coord[i][AXIS_W-1:0];
                    end
                end
                CMD_FORWARD:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        axis_reg[6 + i] <= coord[i][AXIS_W-1:0];
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // products
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                prod_next[3 * a + i] = s1_loc_reg[i] * s1_axis_reg[3 * a + i];
            end
        end
    end

    // dot product sums
    always_comb
    begin
        s3_item_next.proj = s2_proj_reg;
        s3_item_next.tx   = T_W'(s2_prod_reg[0]) + T_W'(s2_prod_reg[1]) + T_W'(s2_prod_reg[2]);
        s3_item_next.ty   = T_W'(s2_prod_reg[3]) + T_W'(s2_prod_reg[4]) + T_W'(s2_prod_reg[5]);
        s3_item_next.tz   = T_W'(s2_prod_reg[6]) + T_W'(s2_prod_reg[7]) + T_W'(s2_prod_reg[8]);
    end

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_proj_reg <= (in_item.cmd == CMD_PROJECT);
            s1_loc_reg  <= loc_next;
            s1_axis_reg <= axis_reg;
        end
        if (en2 && s1_valid_reg)
        begin
            s2_proj_reg <= s1_proj_reg;
            s2_prod_reg <= prod_next;
        end
        if (en3 && s2_valid_reg)
        begin
            s3_item_reg <= s3_item_next;
        end
    end

endmodule

FILE: src/ppp_setup.sv
`timescale 1ns / 1ps

module ppp_setup
    import ppp_pkg::*;
#(
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      in_valid,
    output logic      in_ready,
    input  xf_item_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output div_item_t out_item
);

    localparam int TZ100_W = T_W + 8;
    localparam int MS_W    = MAG_W + SIZE_W;
    localparam logic signed [TZ100_W-1:0] TZ_MIN = TZ100_W'(1) << (COORD_FRAC_BITS + 14);

    logic      valid_reg;
    div_item_t item_reg;
    div_item_t item_next;
    logic      en;

    logic signed [TZ100_W-1:0] tz100;
    logic                      near;
    logic [MAG_W-1:0]          mag_x, mag_y, tz_mag;
    logic [MS_W-1:0]           nx, ny;

    assign en        = !valid_reg || out_ready;
    assign in_ready  = en;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    // depth test, numerators and denominators
    always_comb
    begin
        tz100  = in_item.tz * 8'sd100;
        near   = tz100 < TZ_MIN;
        mag_x  = in_item.tx[T_W-1] ? MAG_W'(-in_item.tx) : MAG_W'(in_item.tx);
        mag_y  = in_item.ty[T_W-1] ? MAG_W'(-in_item.ty) : MAG_W'(in_item.ty);
        tz_mag = in_item.tz[MAG_W-1:0];
        nx     = MS_W'(mag_x) * MS_W'(cfg.screen_w);
        ny     = MS_W'(mag_y) * MS_W'(cfg.screen_h);

        item_next.proj  = in_item.proj;
        item_next.ok    = in_item.proj && !cfg.bad && !near;
        item_next.x.neg = in_item.tx[T_W-1];
        item_next.x.sat = 1'b0;
        item_next.x.rem = REM_W'({nx, {NUM_SHIFT{1'b0}}});
        item_next.x.den = DEN_W'(cfg.fov_x) * DEN_W'(tz_mag);
        item_next.x.q   = '0;
        item_next.y.neg = in_item.ty[T_W-1];
        item_next.y.sat = 1'b0;
        item_next.y.rem = REM_W'({ny, {NUM_SHIFT{1'b0}}});
        item_next.y.den = DEN_W'(cfg.fov_y) * DEN_W'(tz_mag);
        item_next.y.q   = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
        begin
            item_reg <= item_next;
        end
    end

endmodule

FILE: src/ppp_div.sv
`timescale 1ns / 1ps

module ppp_div
    import ppp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  div_item_t in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output div_item_t out_item
);

    localparam int STAGES = QBITS + 1;

    logic      valid_reg [STAGES];
    div_item_t item_reg [STAGES];
    logic      stg_en [STAGES];

    // one quotient bit; the first stage only tests for saturation
    function automatic lane_t div_step(input lane_t cur, input int unsigned k, input logic first);
        lane_t            nxt;
        logic [REM_W-1:0] part;
        nxt  = cur;
        part = REM_W'(cur.den) << k;
        if (first)
        begin
            if (cur.rem >= part)
            begin
                nxt.sat = 1'b1;
                nxt.q   = Q_W'(1) << k;
            end
        end
        else if (!cur.sat && cur.rem >= part)
        begin
            nxt.rem = cur.rem - part;
            nxt.q   = cur.q | (Q_W'(1) << k);
        end
        return nxt;
    endfunction

    assign in_ready  = stg_en[0];
    assign out_valid = valid_reg[STAGES-1];
    assign out_item  = item_reg[STAGES-1];

    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        logic      src_valid;
        div_item_t src_item;
        div_item_t item_next;

        if (s == 0)
        begin : g_first
            assign src_valid = in_valid;
            assign src_item  = in_item;
        end
        else
        begin : g_rest
            assign src_valid = valid_reg[s-1];
            assign src_item  = item_reg[s-1];
        end

        if (s == STAGES - 1)
        begin : g_last_en
            assign stg_en[s] = !valid_reg[s] || out_ready;
        end
        else
        begin : g_mid_en
            assign stg_en[s] = !valid_reg[s] || stg_en[s+1];
        end

        // quotient step on both lanes
        always_comb
        begin
            item_next      = src_item;
            item_next.x    = div_step(src_item.x, (s == 0) ? QBITS : QBITS - s, s == 0);
            item_next.y    = div_step(src_item.y, (s == 0) ? QBITS : QBITS - s, s == 0);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (stg_en[s])
            begin
                valid_reg[s] <= src_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (stg_en[s] && src_valid)
            begin
                item_reg[s] <= item_next;
            end
        end
    end

endmodule

FILE: src/ppp_out.sv
`timescale 1ns / 1ps

module ppp_out
    import ppp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      in_valid,
    output logic      in_ready,
    input  div_item_t in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    localparam int V_W = Q_W + 1;
    localparam logic signed [V_W-1:0] V_MAX = V_W'(SCR_MAX);
    localparam logic signed [V_W-1:0] V_MIN = V_W'(SCR_MIN);

    logic      valid_reg;
    out_item_t item_reg;
    out_item_t item_next;
    logic      en;

    // round the quotient, offset from the screen center and saturate
    function automatic logic signed [SCR_W-1:0] place(input lane_t l,
                                                     input logic [SIZE_W-1:0] size);
        logic [Q_W-1:0]          r;
        logic signed [V_W-1:0]   base;
        logic signed [V_W-1:0]   v;
        logic signed [SCR_W-1:0] res;
        r    = (l.q + Q_W'(1)) >> 1;
        base = V_W'({size, 3'b000});
        v    = l.neg ? base + V_W'(r) : base - V_W'(r);
        if (v > V_MAX)
        begin
            res = SCR_W'(V_MAX);
        end
        else if (v < V_MIN)
        begin
            res = SCR_W'(V_MIN);
        end
        else
        begin
            res = v[SCR_W-1:0];
        end
        return res;
    endfunction

    assign en        = !valid_reg || out_ready;
    assign in_ready  = en;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb
    begin
        item_next.screen_x       = in_item.ok ? place(in_item.x, cfg.screen_w) : '0;
        item_next.screen_y       = in_item.ok ? place(in_item.y, cfg.screen_h) : '0;
        item_next.point_valid    = in_item.ok;
        item_next.was_projection = in_item.proj;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
        begin
            item_reg <= item_next;
        end
    end

endmodule

FILE: src/perspective_point_projection_core.sv
`timescale 1ns / 1ps
`include "perspective_point_projection_core_macros.svh"

// channel   handshake             payload
// req       req_valid/req_ready   req   (cmd, coord_x, coord_y, coord_z)
// rsp       rsp_valid/rsp_ready   rsp   (screen_x, screen_y, point_valid, was_projection)
// cfg       cfg_we                cfg_index, cfg_data
//
// one item per cycle while rsp_ready holds; 3 transform stages (offset, products,
// sums), 1 setup stage, 24 divider stages at one quotient bit each, 1 output
// every stage has its own valid bit and stalls only when it is full and the
// stage behind it cannot move, so bubbles are squeezed out under backpressure
// reset clears the valid bits, the camera state and the registers to defaults

module perspective_point_projection_core
    import ppp_pkg::*;
#(
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  in_item_t              req,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output out_item_t             rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [FOV_W-1:0]  fov_x_reg;
    logic [FOV_W-1:0]  fov_y_reg;
    logic [SIZE_W-1:0] ref_width_reg;
    logic [SIZE_W-1:0] ref_height_reg;
    logic [SIZE_W-1:0] screen_w_reg;
    logic [SIZE_W-1:0] screen_h_reg;

    logic [SIZE_W-1:0] render_w, render_h;
    cfg_t              cfg;

    logic      xf_valid, xf_ready;
    xf_item_t  xf_item;
    logic      su_valid, su_ready;
    div_item_t su_item;
    logic      dv_valid, dv_ready;
    div_item_t dv_item;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fov_x_reg      <= FOV_RESET;
            fov_y_reg      <= FOV_RESET;
            ref_width_reg  <= '0;
            ref_height_reg <= '0;
            screen_w_reg   <= SCREEN_W_RESET;
            screen_h_reg   <= SCREEN_H_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FOV_X:      fov_x_reg      <= cfg_data;
                CFG_FOV_Y:      fov_y_reg      <= cfg_data;
                CFG_REF_WIDTH:  ref_width_reg  <= cfg_data[SIZE_W-1:0];
                CFG_REF_HEIGHT: ref_height_reg <= cfg_data[SIZE_W-1:0];
                CFG_SCREEN_W:   screen_w_reg   <= cfg_data[SIZE_W-1:0];
                CFG_SCREEN_H:   screen_h_reg   <= cfg_data[SIZE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // render size falls back to screen size; any zero size or fov kills the point
    always_comb
    begin
        render_w     = (ref_width_reg != '0) ? ref_width_reg : screen_w_reg;
        render_h     = (ref_height_reg != '0) ? ref_height_reg : screen_h_reg;
        cfg.fov_x    = fov_x_reg;
        cfg.fov_y    = fov_y_reg;
        cfg.screen_w = screen_w_reg;
        cfg.screen_h = screen_h_reg;
        cfg.bad      = (fov_x_reg == '0) || (fov_y_reg == '0) || (screen_w_reg == '0)
                    || (screen_h_reg == '0) || (render_w == '0) || (render_h == '0);
    end

    ppp_xform u_xform (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req_valid),
        .in_ready  (req_ready),
        .in_item   (req),
        .out_valid (xf_valid),
        .out_ready (xf_ready),
        .out_item  (xf_item)
    );

    ppp_setup #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_setup (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (xf_valid),
        .in_ready  (xf_ready),
        .in_item   (xf_item),
        .out_valid (su_valid),
        .out_ready (su_ready),
        .out_item  (su_item)
    );

    ppp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (su_valid),
        .in_ready  (su_ready),
        .in_item   (su_item),
        .out_valid (dv_valid),
        .out_ready (dv_ready),
        .out_item  (dv_item)
    );

    ppp_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (dv_valid),
        .in_ready  (dv_ready),
        .in_item   (dv_item),
        .out_valid (rsp_valid),
        .out_ready (rsp_ready),
        .out_item  (rsp)
    );

    // input side blocks only when the whole pipe is full behind a stalled result
    `PPP_ASSERT_IMPLY(a_full_stall, clk, rst_n, !req_ready, rsp_valid && !rsp_ready)
    // a valid point always comes from a project item
    `PPP_ASSERT_IMPLY(a_valid_proj, clk, rst_n, rsp_valid && rsp.point_valid, rsp.was_projection)
    // clearing the screen width disables projection
    `PPP_ASSERT_NEXT(a_zero_width, clk, rst_n,
        cfg_we && (cfg_index == CFG_SCREEN_W) && (cfg_data[SIZE_W-1:0] == '0), cfg.bad)

endmodule

FILE: verif/perspective_point_projection_core_test.sv
`timescale 1ns / 1ps

module perspective_point_projection_core_test;
    import ppp_pkg::*;

    // keeps the camera state and the registers, predicts one result per item
    class ProjectionScoreboard;
        out_item_t   expected_points[$];
        int          mismatches;
        logic [15:0] fov_x, fov_y;
        logic [12:0] ref_w, ref_h, scr_w, scr_h;
        longint      cam_pos[3];
        longint      axes[9];

        function new();
            mismatches = 0;
            fov_x = FOV_RESET;
            fov_y = FOV_RESET;
            ref_w = '0;
            ref_h = '0;
            scr_w = SCREEN_W_RESET;
            scr_h = SCREEN_H_RESET;
            foreach (cam_pos[i]) cam_pos[i] = 0;
            foreach (axes[i]) axes[i] = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_FOV_X:      fov_x = val;
                CFG_FOV_Y:      fov_y = val;
                CFG_REF_WIDTH:  ref_w = val[12:0];
                CFG_REF_HEIGHT: ref_h = val[12:0];
                CFG_SCREEN_W:   scr_w = val[12:0];
                CFG_SCREEN_H:   scr_h = val[12:0];
                default: ;
            endcase
        endfunction

        // half size times (1 - t/(fov*tz)) in Q16.4, rounded and saturated
        function logic [SCR_W-1:0] screen_coord(longint t, longint tz, longint fov,
                                                longint size);
            logic [127:0] num, den, quo;
            longint mag, r, v;
            mag = (t < 0) ? -t : t;
            num = (128'(mag) * 128'(size)) << 16;
            den = 128'(fov) * 128'(tz);
            quo = num / den;
            if (quo > (128'd1 << 23))
                quo = 128'd1 << 23;
            r = longint'((quo + 128'd1) >> 1);
            v = (t < 0) ? size * 8 + r : size * 8 - r;
            if (v > SCR_MAX) v = SCR_MAX;
            if (v < SCR_MIN) v = SCR_MIN;
            return v[SCR_W-1:0];
        endfunction

        function void note_input(in_item_t it);
            out_item_t res;
            longint    c[3], t[3];
            int        a;
            res = '0;
            c[0] = longint'(it.coord_x);
            c[1] = longint'(it.coord_y);
            c[2] = longint'(it.coord_z);
            case (it.cmd)
                CMD_CAMERA:
                    foreach (cam_pos[i]) cam_pos[i] = c[i];
                CMD_RIGHT, CMD_UP, CMD_FORWARD:
                begin
                    a = int'(it.cmd - CMD_RIGHT);
                    for (int i = 0; i < 3; i++)
                        axes[3*a+i] = longint'($signed(c[i][15:0]));
                end
                CMD_PROJECT:
                begin
                    res.was_projection = 1'b1;
                    if (fov_x != 0 && fov_y != 0 && scr_w != 0 && scr_h != 0)
                    begin
                        for (int k = 0; k < 3; k++)
                        begin
                            t[k] = 0;
                            for (int i = 0; i < 3; i++)
                                t[k] += (c[i] - cam_pos[i]) * axes[3*k+i];
                        end
                        // points closer than 0.01 stay invalid
                        if (t[2] * 100 >= (longint'(1) << (COORD_FRAC_BITS_DEF + 14)))
                        begin
                            res.screen_x = screen_coord(t[0], t[2], fov_x, scr_w);
                            res.screen_y = screen_coord(t[1], t[2], fov_y, scr_h);
                            res.point_valid = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
            expected_points.push_back(res);
        endfunction

        function void check_result(out_item_t got);
            out_item_t exp_r;
            if (expected_points.size() == 0)
            begin
                $display("%0t: unexpected result %h", $realtime, got);
                mismatches++;
                return;
            end
            exp_r = expected_points.pop_front();
            if (got.screen_x !== exp_r.screen_x)
            begin
                $display("%0t: screen_x expected %0d actual %0d", $realtime,
                         exp_r.screen_x, got.screen_x);
                mismatches++;
            end
            if (got.screen_y !== exp_r.screen_y)
            begin
                $display("%0t: screen_y expected %0d actual %0d", $realtime,
                         exp_r.screen_y, got.screen_y);
                mismatches++;
            end
            if (got.point_valid !== exp_r.point_valid)
            begin
                $display("%0t: point_valid expected %b actual %b", $realtime,
                         exp_r.point_valid, got.point_valid);
                mismatches++;
            end
            if (got.was_projection !== exp_r.was_projection)
            begin
                $display("%0t: was_projection expected %b actual %b", $realtime,
                         exp_r.was_projection, got.was_projection);
                mismatches++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  req_valid;
    logic                  req_ready;
    in_item_t              req;
    logic                  rsp_valid;
    logic                  rsp_ready;
    out_item_t             rsp;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ProjectionScoreboard sb = new();
    int burst_left;
    int cycle_count;

    perspective_point_projection_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // watch both channels and the register port
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                sb.write_reg(cfg_index, cfg_data);
            if (req_valid && req_ready)
                sb.note_input(req);
            if (rsp_valid && rsp_ready)
                sb.check_result(rsp);
        end
    end

    // receiver stalls; the mode follows bits 9:8 of cycle_count
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        case ((cycle_count >> 8) % 4)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 1) == 1);
            2: rsp_ready <= ($urandom_range(0, 7) == 0);
            default: rsp_ready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // sender: items in bursts, valid held across a burst
    task automatic send_item(in_item_t it);
        if (burst_left == 0)
        begin
            int gap;
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 10);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_valid <= 1'b1;
        req       <= it;
        do @(posedge clk); while (!req_ready);
    endtask

    task automatic send(logic [CMD_W-1:0] c, logic [31:0] x, logic [31:0] y,
                        logic [31:0] z);
        in_item_t it;
        it.cmd = c;
        it.coord_x = x;
        it.coord_y = y;
        it.coord_z = z;
        send_item(it);
    endtask

    // hold off until all results are back and the pipeline is empty
    task automatic drain();
        req_valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (sb.expected_points.size() != 0);
        repeat (40) @(posedge clk);
    endtask

    // one register write; the caller drops the write enable after the last one
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    function automatic logic [31:0] rnd_axis();
        return {16'($urandom_range(0, 65535)),
                16'($signed($urandom_range(0, 32768)) - 16384)};
    endfunction

    // camera, basis and a run of points around the camera
    task automatic scene_group(int points);
        logic [31:0] cam[3];
        for (int i = 0; i < 3; i++)
            cam[i] = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
        send(CMD_CAMERA, cam[0], cam[1], cam[2]);
        send(CMD_RIGHT, rnd_axis(), rnd_axis(), rnd_axis());
        send(CMD_UP, rnd_axis(), rnd_axis(), rnd_axis());
        send(CMD_FORWARD, rnd_axis(), rnd_axis(), 32'h4000 + $urandom_range(0, 8191));
        for (int p = 0; p < points; p++)
        begin
            logic [31:0] off[3];
            for (int i = 0; i < 3; i++)
                off[i] = $signed($urandom_range(0, 1 << 25)) - (1 << 24);
            if ($urandom_range(0, 3) != 0)
                off[2] = $urandom_range(1 << 10, 1 << 24);
            send(CMD_PROJECT, cam[0] + off[0], cam[1] + off[1], cam[2] + off[2]);
        end
    endtask

    task automatic random_phase(int count);
        int sent;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                int n;
                n = $urandom_range(4, 30);
                scene_group(n);
                sent += n + 4;
            end
            else
            begin
                // noise: any command, full-range fields
                send(CMD_W'($urandom_range(0, 7)), $urandom, $urandom, $urandom);
                sent++;
            end
        end
    endtask

    // directed corners
    task automatic directed();
        send(CMD_PROJECT, 32'h0, 32'h0, 32'h0);
        send(CMD_CAMERA, 32'h0, 32'h0, 32'h0);
        send(CMD_RIGHT, 32'h4000, 32'h0, 32'h0);
        send(CMD_UP, 32'h0, 32'h4000, 32'h0);
        send(CMD_FORWARD, 32'h0, 32'h0, 32'h4000);
        send(CMD_PROJECT, 32'h1000, 32'h800, 32'h1000);
        // depth just below and just above 0.01
        send(CMD_PROJECT, 32'h0, 32'h0, 32'd40);
        send(CMD_PROJECT, 32'h0, 32'h0, 32'd41);
        // behind the camera
        send(CMD_PROJECT, 32'h1000, 32'h1000, 32'hFFFF_F000);
        // tiny depth, wide offset: saturation
        send(CMD_PROJECT, 32'h7FFF_FFFF, 32'h8000_0000, 32'd50);
        send(CMD_PROJECT, 32'h8000_0000, 32'h7FFF_FFFF, 32'd50);
        // unknown commands leave the state alone
        for (int c = 5; c < 8; c++)
            send(CMD_W'(c), 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        // extreme positions and axes
        send(CMD_CAMERA, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send(CMD_RIGHT, 32'hFFFF_8000, 32'h0000_7FFF, 32'hFFFF_8000);
        send(CMD_UP, 32'h0000_7FFF, 32'hABCD_8000, 32'h0000_7FFF);
        send(CMD_FORWARD, 32'h1234_7FFF, 32'h0000_7FFF, 32'h0000_7FFF);
        send(CMD_PROJECT, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send(CMD_PROJECT, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send(CMD_PROJECT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    task automatic set_regs(logic [15:0] fx, logic [15:0] fy, logic [15:0] rw,
                            logic [15:0] rh, logic [15:0] sw, logic [15:0] sh);
        write_reg(CFG_FOV_X, fx);
        write_reg(CFG_FOV_Y, fy);
        write_reg(CFG_REF_WIDTH, rw);
        write_reg(CFG_REF_HEIGHT, rh);
        write_reg(CFG_SCREEN_W, sw);
        write_reg(CFG_SCREEN_H, sh);
        cfg_we <= 1'b0;
    endtask

    // main sequence
    initial
    begin
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req         = '0;
        rsp_ready   = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        cycle_count = 0;
        burst_left  = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed();
        random_phase(120);
        drain();
        random_phase(100);
        drain();

        set_regs(16'd1, 16'hFFFF, 16'd640, 16'd480, 16'd8191, 16'd1);
        directed();
        random_phase(230);
        drain();

        set_regs(16'hFFFF, 16'd1, 16'h1FFF, 16'h1FFF, 16'd1, 16'd8191);
        random_phase(230);
        drain();

        set_regs(16'd0, 16'd4096, 16'd0, 16'd0, 16'd1920, 16'd1080);
        random_phase(60);
        drain();

        set_regs(16'd4096, 16'd0, 16'd100, 16'd0, 16'd1280, 16'd720);
        random_phase(60);
        drain();

        set_regs(16'd2048, 16'd3000, 16'd0, 16'd0, 16'd0, 16'd720);
        random_phase(60);
        drain();

        set_regs(16'd3000, 16'd5000, 16'hE123, 16'hF456, 16'hE000 | 16'd800,
                 16'd0);
        random_phase(60);
        drain();

        set_regs(16'd8192, 16'd2896, 16'd1024, 16'd768, 16'd3840, 16'd2160);
        directed();
        random_phase(380);
        drain();

        set_regs(16'h8001, 16'h7FFE, 16'h1555, 16'h0AAA, 16'h1AAA, 16'h0555);
        random_phase(350);
        drain();

        if (sb.mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // timeout
    initial
    begin
        #4000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
